[rtl/csou_pkg.sv]
`default_nettype none

package csou_pkg;

  // Angle format: fixed-point degrees
  localparam int ANGLE_FRAC_BITS = 10;
  localparam int ANG_W           = 9 + ANGLE_FRAC_BITS;
  localparam int TOL_W           = 10;
  localparam int OP_W            = 2;
  // Doubled-resolution edges need a signed word covering about +/-11 turns
  localparam int EDGE_W          = ANG_W + 5;

  localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(180 << ANGLE_FRAC_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_OVERLAP   = 2'd0,
    OP_UNION     = 2'd1,
    OP_INTERSECT = 2'd2
  } op_e;

  // Normalised operands and overlap classification
  typedef struct packed {
    logic [ANG_W-1:0] ra;
    logic [ANG_W-1:0] wa;
    logic [ANG_W-1:0] rb;
    logic [ANG_W-1:0] wb;
    logic             full_a;
    logic             full_b;
    logic             ovl;
  } sect_t;

  // One result transaction
  typedef struct packed {
    logic             overlaps;
    logic [ANG_W-1:0] result_rotation;
    logic [ANG_W-1:0] result_width;
    logic             result_empty;
  } res_t;

  // Rotation below two turns reduced into [0, FULL)
  function automatic logic [ANG_W-1:0] norm_rot(input logic [ANG_W-1:0] r);
    return (r >= FULL_TURN) ? ANG_W'(r - FULL_TURN) : r;
  endfunction

  function automatic logic [ANG_W-1:0] clamp_width(input logic [ANG_W-1:0] w);
    return (w > FULL_TURN) ? FULL_TURN : w;
  endfunction

  // Zero-extend an angle into the signed edge word
  function automatic logic signed [EDGE_W-1:0] to_edge(input logic [ANG_W-1:0] v);
    return signed'({{(EDGE_W-ANG_W){1'b0}}, v});
  endfunction

endpackage

`default_nettype wire

[rtl/csou_if.sv]
`default_nettype none

// Input channel: one pair of sectors and an operation
interface csou_in_if import csou_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [ANG_W-1:0] a_rotation;
  logic [ANG_W-1:0] a_width;
  logic [ANG_W-1:0] b_rotation;
  logic [ANG_W-1:0] b_width;

  modport source (output valid, operation, a_rotation, a_width, b_rotation, b_width,
                  input ready);
  modport sink (input valid, operation, a_rotation, a_width, b_rotation, b_width,
                output ready);
endinterface

// Output channel: overlap flag and result sector
interface csou_out_if import csou_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             overlaps;
  logic [ANG_W-1:0] result_rotation;
  logic [ANG_W-1:0] result_width;
  logic             result_empty;

  modport source (output valid, overlaps, result_rotation, result_width, result_empty,
                  input ready);
  modport sink (input valid, overlaps, result_rotation, result_width, result_empty,
                output ready);
endinterface

`default_nettype wire

[rtl/csou_prep.sv]
`default_nettype none

// Operand normalisation, full-circle detection and overlap test
module csou_prep import csou_pkg::*; (
  input  logic [ANG_W-1:0] a_rotation_i,
  input  logic [ANG_W-1:0] a_width_i,
  input  logic [ANG_W-1:0] b_rotation_i,
  input  logic [ANG_W-1:0] b_width_i,
  input  logic [TOL_W-1:0] tol_i,
  output sect_t            sect_o
);

  logic [ANG_W-1:0] ra, wa, rb, wb;
  logic [ANG_W-1:0] gap_raw, gap;
  logic [ANG_W:0]   wa_tol, wb_tol;
  logic [ANG_W+1:0] lhs, rhs;

  assign ra = norm_rot(a_rotation_i);
  assign rb = norm_rot(b_rotation_i);
  assign wa = clamp_width(a_width_i);
  assign wb = clamp_width(b_width_i);

  // Full circle within tolerance: w + tol >= FULL
  assign wa_tol = {1'b0, wa} + (ANG_W+1)'(tol_i);
  assign wb_tol = {1'b0, wb} + (ANG_W+1)'(tol_i);

  // Shortest angular distance between centres
  assign gap_raw = (ra > rb) ? ANG_W'(ra - rb) : ANG_W'(rb - ra);
  assign gap     = (gap_raw > HALF_TURN) ? ANG_W'(FULL_TURN - gap_raw) : gap_raw;

  // 2d <= wa + wb + 2 tol
  assign lhs = {1'b0, gap, 1'b0};
  assign rhs = (ANG_W+2)'(wa) + (ANG_W+2)'(wb) + (ANG_W+2)'({tol_i, 1'b0});

  always_comb begin
    sect_o.ra     = ra;
    sect_o.wa     = wa;
    sect_o.rb     = rb;
    sect_o.wb     = wb;
    sect_o.full_a = (wa_tol >= (ANG_W+1)'(FULL_TURN));
    sect_o.full_b = (wb_tol >= (ANG_W+1)'(FULL_TURN));
    sect_o.ovl    = sect_o.full_a || sect_o.full_b || (lhs <= rhs);
  end

endmodule

`default_nettype wire

[rtl/csou_combine.sv]
`default_nettype none

// Union / intersection on doubled-resolution edges
module csou_combine import csou_pkg::*; (
  input  sect_t            sect_i,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [TOL_W-1:0] tol_i,
  output res_t             res_o
);

  localparam logic signed [EDGE_W-1:0] FULL_S     = to_edge(FULL_TURN);
  localparam logic signed [EDGE_W-1:0] HALF_S     = to_edge(HALF_TURN);
  localparam logic signed [EDGE_W-1:0] NEG_HALF_S = -HALF_S;
  localparam logic signed [EDGE_W-1:0] TWO_FULL_S = FULL_S + FULL_S;

  logic signed [EDGE_W-1:0] ra_s, wa_s, rb_s, wb_s, diff, rb_adj, tol2_s;
  logic signed [EDGE_W-1:0] s2a, e2a, s2b, e2b;
  logic signed [EDGE_W-1:0] u_lo, u_hi, u_w2, u_half;
  logic signed [EDGE_W-1:0] i_lo, i_hi, i_w2, i_half;
  logic signed [EDGE_W-1:0] u_q, i_q, u_c, i_c;
  op_e                      op;

  assign op     = op_e'(operation_i);
  assign ra_s   = to_edge(sect_i.ra);
  assign wa_s   = to_edge(sect_i.wa);
  assign rb_s   = to_edge(sect_i.rb);
  assign wb_s   = to_edge(sect_i.wb);
  assign tol2_s = signed'({{(EDGE_W-TOL_W-1){1'b0}}, tol_i, 1'b0});

  // Bring B within half a turn of A
  assign diff = rb_s - ra_s;
  always_comb begin
    if (diff > HALF_S) begin
      rb_adj = rb_s - FULL_S;
    end else if (diff < NEG_HALF_S) begin
      rb_adj = rb_s + FULL_S;
    end else begin
      rb_adj = rb_s;
    end
  end

  // Edges at twice the resolution
  assign s2a = (ra_s <<< 1) - wa_s;
  assign e2a = (ra_s <<< 1) + wa_s;
  assign s2b = (rb_adj <<< 1) - wb_s;
  assign e2b = (rb_adj <<< 1) + wb_s;

  // Union span
  assign u_lo   = (s2a < s2b) ? s2a : s2b;
  assign u_hi   = (e2a > e2b) ? e2a : e2b;
  assign u_w2   = u_hi - u_lo;
  assign u_half = u_w2 >>> 1;

  // Intersection span
  assign i_lo   = (s2a > s2b) ? s2a : s2b;
  assign i_hi   = (e2a < e2b) ? e2a : e2b;
  assign i_w2   = i_hi - i_lo;
  assign i_half = i_w2 >>> 1;

  // Centre = floor(sum/4), folded once into [0, FULL)
  assign u_q = (u_lo + u_hi) >>> 2;
  assign i_q = (i_lo + i_hi) >>> 2;

  always_comb begin
    if (u_q < 0) begin
      u_c = u_q + FULL_S;
    end else if (u_q >= FULL_S) begin
      u_c = u_q - FULL_S;
    end else begin
      u_c = u_q;
    end
    if (i_q < 0) begin
      i_c = i_q + FULL_S;
    end else if (i_q >= FULL_S) begin
      i_c = i_q - FULL_S;
    end else begin
      i_c = i_q;
    end
  end

  // Result selection
  always_comb begin
    res_o                 = '0;
    res_o.overlaps        = sect_i.ovl;
    case (op)
      OP_UNION: begin
        if (!sect_i.ovl) begin
          res_o.result_empty = 1'b1;
        end else if (sect_i.full_a || sect_i.full_b) begin
          res_o.result_width = FULL_TURN;
        end else if (u_w2 >= TWO_FULL_S - tol2_s) begin
          res_o.result_width = FULL_TURN;
        end else begin
          res_o.result_width    = u_half[ANG_W-1:0];
          res_o.result_rotation = u_c[ANG_W-1:0];
        end
      end
      OP_INTERSECT: begin
        if (!sect_i.ovl) begin
          res_o.result_empty = 1'b1;
        end else if (sect_i.full_a) begin
          res_o.result_rotation = sect_i.rb;
          res_o.result_width    = sect_i.wb;
        end else if (sect_i.full_b) begin
          res_o.result_rotation = sect_i.ra;
          res_o.result_width    = sect_i.wa;
        end else if (i_w2 <= tol2_s) begin
          res_o.result_empty = 1'b1;
        end else begin
          res_o.result_width    = (i_half > FULL_S) ? FULL_TURN : i_half[ANG_W-1:0];
          res_o.result_rotation = i_c[ANG_W-1:0];
        end
      end
      default: begin
        // overlap test: flag only
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/circular_sector_overlap_union_meet.sv]
`default_nettype none

// Circular sector overlap / union / intersection. Takes one transaction per clock
// when the output side keeps up: each item is captured in an input register,
// passes one combinational stage (normalisation, overlap test, edge merge) and
// lands in the result register, which takes it when free or being read. That
// single pass between the two registers sets the throughput of one item per cycle
// while the output keeps up; the result register lets a new item enter while a
// finished result is still waiting. angle_tolerance (reset 1) is written via
// cfg_we_i / cfg_wdata_i and must only be changed while the block is idle.
module circular_sector_overlap_union_meet import csou_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i,
  csou_in_if.sink          in_i,
  csou_out_if.source       out_o
);

  // Configuration
  logic [TOL_W-1:0] tol_q;

  // Input register
  logic             s1_valid_q, s1_valid_d;
  logic [OP_W-1:0]  op_q;
  logic [ANG_W-1:0] a_rot_q, a_wid_q, b_rot_q, b_wid_q;

  // Result register
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic             in_acc, out_load, s1_adv;
  sect_t            sect;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Flow control
  assign out_load   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_load;
  assign in_i.ready = !s1_valid_q || out_load;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_load ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_i.operation;
      a_rot_q <= in_i.a_rotation;
      a_wid_q <= in_i.a_width;
      b_rot_q <= in_i.b_rotation;
      b_wid_q <= in_i.b_width;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  // Single combinational pass
  csou_prep u_prep (
    .a_rotation_i (a_rot_q),
    .a_width_i    (a_wid_q),
    .b_rotation_i (b_rot_q),
    .b_width_i    (b_wid_q),
    .tol_i        (tol_q),
    .sect_o       (sect)
  );

  csou_combine u_combine (
    .sect_i      (sect),
    .operation_i (op_q),
    .tol_i       (tol_q),
    .res_o       (res_d)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.overlaps        = res_q.overlaps;
  assign out_o.result_rotation = res_q.result_rotation;
  assign out_o.result_width    = res_q.result_width;
  assign out_o.result_empty    = res_q.result_empty;

  // Checks
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled while a stage is free");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced transaction not in result register");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.result_empty) |->
      (res_q.result_rotation == '0 && res_q.result_width == '0))
    else $error("empty result carries a sector");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.result_rotation < FULL_TURN && res_q.result_width <= FULL_TURN))
    else $error("result sector out of range");

endmodule

`default_nettype wire

[tb/circular_sector_overlap_union_meet_tb.sv]
`default_nettype none

module circular_sector_overlap_union_meet_tb;
  import csou_pkg::*;

  // Wide copies of the angle constants for the predictor arithmetic
  localparam longint TURN_L = longint'(360) << ANGLE_FRAC_BITS;
  localparam longint HALF_L = TURN_L / 2;

  // Spare operation code, handled by the block as an overlap test
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 110;
  localparam int SLACK_ITEMS    = 50;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [TOL_W-1:0] cfg_wdata;

  csou_in_if  in_if ();
  csou_out_if out_if ();

  circular_sector_overlap_union_meet DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor copy of the tolerance register
  logic [TOL_W-1:0] angle_slack;
  // Results owed by the block, oldest first
  res_t             sector_results_due[$];
  int               mismatch_count = 0;
  int               quiet_cycles = 0;
  int unsigned      sender_idle_pct = 0;
  int unsigned      receiver_stall_pct = 0;

  // Clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Sector algebra: overlap test, union, intersection
  function automatic res_t predict_sector_result(input logic [OP_W-1:0]  op,
                                                 input logic [ANG_W-1:0] a_rot,
                                                 input logic [ANG_W-1:0] a_wid,
                                                 input logic [ANG_W-1:0] b_rot,
                                                 input logic [ANG_W-1:0] b_wid,
                                                 input logic [TOL_W-1:0] slack);
    longint ra, wa, rb, wb, tol, gap, s2a, e2a, s2b, e2b, lo, hi, w2, wid, rot;
    logic   full_a, full_b, ovl;
    res_t   r;
    r   = '0;
    ra  = a_rot;
    rb  = b_rot;
    wa  = a_wid;
    wb  = b_wid;
    tol = slack;
    if (ra >= TURN_L) ra -= TURN_L;
    if (rb >= TURN_L) rb -= TURN_L;
    if (wa > TURN_L) wa = TURN_L;
    if (wb > TURN_L) wb = TURN_L;
    full_a = (wa >= TURN_L - tol);
    full_b = (wb >= TURN_L - tol);
    gap    = (ra > rb) ? ra - rb : rb - ra;
    if (gap > HALF_L) gap = TURN_L - gap;
    ovl = full_a || full_b || (2 * gap <= wa + wb + 2 * tol);
    r.overlaps = ovl;
    if (op == OP_UNION || op == OP_INTERSECT) begin
      if (!ovl) begin
        r.result_empty = 1'b1;
      end else if (op == OP_UNION && (full_a || full_b)) begin
        r.result_width = ANG_W'(TURN_L);
      end else if (op == OP_INTERSECT && full_a) begin
        r.result_rotation = ANG_W'(rb);
        r.result_width    = ANG_W'(wb);
      end else if (op == OP_INTERSECT && full_b) begin
        r.result_rotation = ANG_W'(ra);
        r.result_width    = ANG_W'(wa);
      end else begin
        // bring B within half a turn of A, edges at doubled resolution
        if (rb - ra > HALF_L) rb -= TURN_L;
        else if (rb - ra < -HALF_L) rb += TURN_L;
        s2a = 2 * ra - wa;
        e2a = 2 * ra + wa;
        s2b = 2 * rb - wb;
        e2b = 2 * rb + wb;
        if (op == OP_UNION) begin
          lo = (s2a < s2b) ? s2a : s2b;
          hi = (e2a > e2b) ? e2a : e2b;
        end else begin
          lo = (s2a > s2b) ? s2a : s2b;
          hi = (e2a < e2b) ? e2a : e2b;
        end
        w2  = hi - lo;
        wid = w2 / 2;
        rot = ((lo + hi + 16 * TURN_L) / 4) % TURN_L;
        if (op == OP_UNION && w2 >= 2 * TURN_L - 2 * tol) begin
          r.result_width = ANG_W'(TURN_L);
        end else if (op == OP_INTERSECT && w2 <= 2 * tol) begin
          r.result_empty = 1'b1;
        end else begin
          if (wid > TURN_L) wid = TURN_L;
          r.result_width    = ANG_W'(wid);
          r.result_rotation = ANG_W'(rot);
        end
      end
    end
    return r;
  endfunction

  // Result side: random back-pressure
  always @(negedge clk) begin
    out_if.ready = !($urandom_range(99) < receiver_stall_pct);
  end

  // Result side: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    res_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (sector_results_due.size() == 0) begin
        $error("unexpected result transaction");
        mismatch_count++;
      end else begin
        exp_res = sector_results_due.pop_front();
        if (out_if.overlaps !== exp_res.overlaps) begin
          $error("overlaps: expected %0d, got %0d", exp_res.overlaps, out_if.overlaps);
          mismatch_count++;
        end
        if (out_if.result_rotation !== exp_res.result_rotation) begin
          $error("result_rotation: expected %0d, got %0d",
                 exp_res.result_rotation, out_if.result_rotation);
          mismatch_count++;
        end
        if (out_if.result_width !== exp_res.result_width) begin
          $error("result_width: expected %0d, got %0d",
                 exp_res.result_width, out_if.result_width);
          mismatch_count++;
        end
        if (out_if.result_empty !== exp_res.result_empty) begin
          $error("result_empty: expected %0d, got %0d",
                 exp_res.result_empty, out_if.result_empty);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: cycles without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("circular_sector_overlap_union_meet_tb failed");
      $finish;
    end
  end

  // One input transaction, with random idle cycles ahead of it
  task automatic send_sector_pair(input logic [OP_W-1:0]  op,
                                  input logic [ANG_W-1:0] ar,
                                  input logic [ANG_W-1:0] aw,
                                  input logic [ANG_W-1:0] br,
                                  input logic [ANG_W-1:0] bw);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.operation  = op;
    in_if.a_rotation = ar;
    in_if.a_width    = aw;
    in_if.b_rotation = br;
    in_if.b_width    = bw;
    do @(posedge clk); while (!in_if.ready);
    sector_results_due.push_back(predict_sector_result(op, ar, aw, br, bw, angle_slack));
  endtask

  // Stop sending and wait for every owed result, then let the pipe settle
  task automatic hold_until_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sector_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    hold_until_drained();
    @(negedge clk);
    cfg_we      = 1'b1;
    cfg_wdata   = value;
    angle_slack = value;
    @(negedge clk);
    cfg_we      = 1'b0;
  endtask

  // Widths clustered on the interesting points: zero, tolerance, full circle
  function automatic logic [ANG_W-1:0] pick_width();
    case ($urandom_range(9))
      0: return '0;
      1: return ANG_W'($urandom_range(3));
      2: return ANG_W'(TURN_L - angle_slack - 1 + $urandom_range(2));
      3: return ANG_W'(TURN_L);
      4: return ANG_W'($urandom_range(TURN_L));
      5, 6: return ANG_W'($urandom_range(TURN_L / 8));
      7: return ANG_W'($urandom_range(2 * angle_slack + 4));
      default: return ANG_W'($urandom_range(TURN_L / 2));
    endcase
  endfunction

  // Mostly B placed around the overlap boundary of A; some raw noise
  task automatic send_random_pair();
    logic [OP_W-1:0]  op;
    logic [ANG_W-1:0] ar, aw, br, bw;
    longint           reach, offset, brv;
    int unsigned      kind;
    kind = $urandom_range(99);
    op   = ($urandom_range(15) == 0) ? OP_UNUSED : OP_W'($urandom_range(2));
    if (kind < 15) begin
      ar = ANG_W'($urandom);
      aw = ANG_W'($urandom);
      br = ANG_W'($urandom);
      bw = ANG_W'($urandom);
    end else begin
      ar = ANG_W'($urandom_range(TURN_L - 1));
      aw = pick_width();
      bw = pick_width();
      if (kind < 25) begin
        // centres about half a turn apart
        brv = longint'(ar) + HALF_L + longint'($urandom_range(8)) - 4;
      end else begin
        reach  = (longint'(aw) + longint'(bw)) / 2 + angle_slack + 2;
        offset = $urandom_range(reach);
        brv    = $urandom_range(1) ? longint'(ar) + offset : longint'(ar) - offset;
      end
      brv = brv % TURN_L;
      if (brv < 0) brv += TURN_L;
      br = ANG_W'(brv);
    end
    send_sector_pair(op, ar, aw, br, bw);
  endtask

  // Edge and special cases at the reset tolerance
  task automatic test_directed_cases();
    logic [ANG_W-1:0] ones;
    ones = '1;
    send_sector_pair(OP_OVERLAP,   0, 0, 0, 0);
    send_sector_pair(OP_UNION,     0, 0, 0, 0);
    send_sector_pair(OP_INTERSECT, 0, 0, 0, 0);
    // across the zero crossing
    send_sector_pair(OP_OVERLAP,   ANG_W'(FULL_TURN - 1), 2, 0, 2);
    send_sector_pair(OP_UNION,     ANG_W'(FULL_TURN - 1024), 4096, 1024, 4096);
    send_sector_pair(OP_INTERSECT, ANG_W'(FULL_TURN - 1024), 4096, 1024, 4096);
    send_sector_pair(OP_UNION,     ANG_W'(FULL_TURN - 1), 0, 0, 0);
    // full circles, exact and by tolerance, and one just short of it
    send_sector_pair(OP_UNION,     1000, FULL_TURN, 200000, 50);
    send_sector_pair(OP_INTERSECT, 1000, FULL_TURN, 200000, 50);
    send_sector_pair(OP_INTERSECT, 1000, 777, 200000, FULL_TURN);
    send_sector_pair(OP_INTERSECT, 5000, ANG_W'(FULL_TURN - 1), 9000, 300);
    send_sector_pair(OP_UNION,     5000, ANG_W'(FULL_TURN - 2), 9000, 300);
    // disjoint sectors give the empty sector
    send_sector_pair(OP_UNION,     0, 1000, HALF_TURN, 1000);
    send_sector_pair(OP_INTERSECT, 0, 1000, HALF_TURN, 1000);
    // touching edges: overlap but empty meet; then a meet just over tolerance
    send_sector_pair(OP_INTERSECT, 0, 2048, 2048, 2048);
    send_sector_pair(OP_INTERSECT, 0, 2052, 2048, 2048);
    // union wide enough to snap to a full circle
    send_sector_pair(OP_UNION,     0, ANG_W'(FULL_TURN - 100), HALF_TURN,
                     ANG_W'(FULL_TURN - 100));
    send_sector_pair(OP_UNUSED,    100, 200, 300, 400);
    // rotation past a turn, width past a full circle
    send_sector_pair(OP_OVERLAP,   ones, ones, FULL_TURN, 0);
    send_sector_pair(OP_INTERSECT, ones, ones, ones, ones);
    // odd edge sums truncate
    send_sector_pair(OP_UNION,     0, 3, 1, 3);
    send_sector_pair(OP_INTERSECT, 1, 5, 2, 4);
    // centres exactly half a turn apart
    send_sector_pair(OP_OVERLAP,   0, HALF_TURN, HALF_TURN, HALF_TURN);
  endtask

  // Random traffic at several tolerance settings, extremes included
  task automatic test_tolerance_settings();
    logic [TOL_W-1:0] slack_set[4];
    slack_set[0] = '0;
    slack_set[1] = '1;
    slack_set[2] = TOL_W'($urandom_range(1022, 2));
    slack_set[3] = TOL_W'(1);
    foreach (slack_set[k]) begin
      write_tolerance(slack_set[k]);
      sender_idle_pct    = (k % 2) ? 19 : 0;
      receiver_stall_pct = (k % 2) ? 19 : 0;
      repeat (SLACK_ITEMS) send_random_pair();
    end
  endtask

  // Random traffic under each idling pattern; the sender drains once mid-phase
  task automatic test_idle_phases();
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    idle_set  = '{0, 62, 0, 19};
    stall_set = '{0, 0, 62, 19};
    foreach (idle_set[k]) begin
      sender_idle_pct    = idle_set[k];
      receiver_stall_pct = stall_set[k];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) hold_until_drained();
        send_random_pair();
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    angle_slack      = TOL_W'(1);
    in_if.valid      = 1'b0;
    in_if.operation  = OP_OVERLAP;
    in_if.a_rotation = '0;
    in_if.a_width    = '0;
    in_if.b_rotation = '0;
    in_if.b_width    = '0;
    out_if.ready     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_tolerance_settings();
    test_idle_phases();
    hold_until_drained();

    if (mismatch_count == 0 && sector_results_due.size() == 0) begin
      $display("circular_sector_overlap_union_meet_tb passed");
    end else begin
      $display("circular_sector_overlap_union_meet_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/csou_pkg.sv
rtl/csou_if.sv
rtl/csou_prep.sv
rtl/csou_combine.sv
rtl/circular_sector_overlap_union_meet.sv
tb/circular_sector_overlap_union_meet_tb.sv
